>>> rtl/wvcs_pkg.sv
// ----------------------------------------------------------------------------
// wvcs_pkg
// Shared types and constants of the wheel velocity command shaper.
// ----------------------------------------------------------------------------
package wvcs_pkg;

	// defaults of the top level parameters
	localparam int WVCS_NUM_AXES      = 2;
	localparam int WVCS_VEL_FRAC_BITS = 16;

	// field widths
	localparam int VEL_W  = 24;   // signed velocity, Q8.f
	localparam int VLIM_W = 23;   // unsigned velocity / accel limit
	localparam int CUR_W  = 16;   // current limit, Q8.8
	localparam int DT_W   = 16;   // tick time, Q0.16
	localparam int MASK_W = 2;    // manual enable mask

	// slew bypass threshold, whole turns per second
	localparam int SLEW_BYPASS_TURNS = 4;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BALANCE_ENABLE     = 3'd0,
		REG_MANUAL_ENABLE_MASK = 3'd1,
		REG_VELOCITY_LIMIT     = 3'd2,
		REG_ACCEL_LIMIT        = 3'd3,
		REG_ROTATION_ERR_GAIN  = 3'd4,
		REG_CURRENT_LIM_NORMAL = 3'd5,
		REG_CURRENT_LIM_LAND   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		REQ_NONE        = 2'd0,
		REQ_CLOSED_LOOP = 2'd1,
		REQ_IDLE        = 2'd2
	} state_req_t;

endpackage

>>> rtl/wheel_velocity_command_shaper_unit.sv
// ----------------------------------------------------------------------------
// wheel_velocity_command_shaper_unit
// One control tick per request for one wheel axis: run decision, current
// limit selection, velocity source selection, slew limit and final clamp.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   -----------------------------------------
//  in        in_valid / in_stall       axis_select .. tick_time (one tick)
//  out       out_valid / out_stall     axis_out .. accel_limit_applied
//  config    psel/penable/pwrite/...   7 registers at byte address 4*index
//
//  one request per cycle sustained unless out_stall holds the result; each
//  request passes the input stage (gain multiply and accel*dt), then the per-axis stage
//  per-axis state is read and updated as a request leaves the input stage,
//  so back-to-back requests on the same axis see each other's updates
//  reset clears configuration, per-axis state and both valid flags
//  out_stall holds the result register; in_stall rises only when both stages
//  are full and the result is held
//
module wheel_velocity_command_shaper_unit
	import wvcs_pkg::*;
#(
	parameter int NUM_AXES      = WVCS_NUM_AXES,
	parameter int VEL_FRAC_BITS = WVCS_VEL_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,

	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0]    pwdata,
	output logic [APB_DATA_W-1:0]    prdata,
	output logic                     pready,

	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     axis_select,
	input  logic signed [VEL_W-1:0]  balance_velocity,
	input  logic signed [VEL_W-1:0]  rotation_velocity,
	input  logic signed [VEL_W-1:0]  side_correction,
	input  logic signed [VEL_W-1:0]  rotation_error,
	input  logic signed [VEL_W-1:0]  smoothed_velocity,
	input  logic signed [VEL_W-1:0]  manual_velocity,
	input  logic                     robot_standing,
	input  logic                     landing_active,
	input  logic                     index_search_phase,
	input  logic                     motor_ready,
	input  logic [DT_W-1:0]          tick_time,

	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     axis_out,
	output logic signed [VEL_W-1:0]  velocity_command,
	output logic                     running,
	output logic [1:0]               state_request,
	output logic                     current_limit_write,
	output logic [CUR_W-1:0]         current_limit_value,
	output logic                     accel_limit_applied
);

	// widths derived from the fraction size
	localparam int SLOT_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int PROD_W  = 2 * VEL_W;
	localparam int TERM_W  = PROD_W - VEL_FRAC_BITS;   // gain term after the shift
	localparam int SUM_W   = TERM_W + 2;               // four-term balance sum
	localparam int DIFF_W  = SUM_W + 1;                // target minus previous
	localparam int FAR_W   = VEL_W + 2;                // slip distance
	localparam int STEP_P_W = VLIM_W + DT_W;           // accel * dt product

	localparam logic signed [SUM_W-1:0] INDEX_SPEED =
		SUM_W'(1) << (VEL_FRAC_BITS - 1);
	localparam logic signed [FAR_W-1:0] FAR_LIMIT =
		FAR_W'(SLEW_BYPASS_TURNS) << VEL_FRAC_BITS;

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	logic                     balance_enable_q;
	logic [MASK_W-1:0]        manual_enable_mask_q;
	logic [VLIM_W-1:0]        velocity_limit_q;
	logic [VLIM_W-1:0]        accel_limit_q;
	logic signed [VEL_W-1:0]  rotation_error_gain_q;
	logic [CUR_W-1:0]         current_limit_normal_q;
	logic [CUR_W-1:0]         current_limit_landing_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[REG_IDX_W+1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balance_enable_q        <= 1'b0;
			manual_enable_mask_q    <= '0;
			velocity_limit_q        <= '0;
			accel_limit_q           <= '0;
			rotation_error_gain_q   <= '0;
			current_limit_normal_q  <= '0;
			current_limit_landing_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BALANCE_ENABLE:     balance_enable_q        <= pwdata[0];
				REG_MANUAL_ENABLE_MASK: manual_enable_mask_q    <= pwdata[MASK_W-1:0];
				REG_VELOCITY_LIMIT:     velocity_limit_q        <= pwdata[VLIM_W-1:0];
				REG_ACCEL_LIMIT:        accel_limit_q           <= pwdata[VLIM_W-1:0];
				REG_ROTATION_ERR_GAIN:  rotation_error_gain_q   <= pwdata[VEL_W-1:0];
				REG_CURRENT_LIM_NORMAL: current_limit_normal_q  <= pwdata[CUR_W-1:0];
				REG_CURRENT_LIM_LAND:   current_limit_landing_q <= pwdata[CUR_W-1:0];
				default: ;  // unmapped address, write dropped
			endcase
		end
	end

	// readback, gain is sign extended
	always_comb begin
		case (cfg_idx)
			REG_BALANCE_ENABLE:     prdata = APB_DATA_W'(balance_enable_q);
			REG_MANUAL_ENABLE_MASK: prdata = APB_DATA_W'(manual_enable_mask_q);
			REG_VELOCITY_LIMIT:     prdata = APB_DATA_W'(velocity_limit_q);
			REG_ACCEL_LIMIT:        prdata = APB_DATA_W'(accel_limit_q);
			REG_ROTATION_ERR_GAIN:  prdata = APB_DATA_W'(rotation_error_gain_q);
			REG_CURRENT_LIM_NORMAL: prdata = APB_DATA_W'(current_limit_normal_q);
			REG_CURRENT_LIM_LAND:   prdata = APB_DATA_W'(current_limit_landing_q);
			default:                prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// handshake: input stage s1, result register behind it
	// ------------------------------------------------------------------------
	logic valid_s1;
	logic out_valid_q;
	logic s1_go;      // s1 content may move into the result register
	logic s1_fire;    // a request actually moves, per-axis state updates

	assign s1_go    = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && s1_go;
	assign in_stall = valid_s1 && !s1_go;

	// ------------------------------------------------------------------------
	// input stage: stateless terms, gain multiply and slew step
	// ------------------------------------------------------------------------
	logic signed [PROD_W-1:0]   err_prod;
	logic signed [PROD_W-1:0]   err_prod_sh;
	logic [STEP_P_W-1:0]        step_prod;
	logic                       run_in;
	logic                       index_drive_in;

	// floor shift of the gain product, as an arithmetic shift
	assign err_prod    = rotation_error * rotation_error_gain_q;
	assign err_prod_sh = err_prod >>> VEL_FRAC_BITS;
	assign step_prod   = STEP_P_W'(accel_limit_q) * STEP_P_W'(tick_time);

	assign index_drive_in = index_search_phase & motor_ready;
	assign run_in = manual_enable_mask_q[axis_select]
		| (balance_enable_q & robot_standing)
		| index_drive_in;

	logic                       axis_s1;
	logic signed [VEL_W-1:0]    bal_s1;
	logic signed [VEL_W-1:0]    rot_s1;
	logic signed [VEL_W-1:0]    corr_s1;
	logic signed [TERM_W-1:0]   term_s1;
	logic signed [VEL_W-1:0]    smooth_s1;
	logic signed [VEL_W-1:0]    manual_s1;
	logic                       run_s1;
	logic                       index_drive_s1;
	logic                       landing_s1;
	logic [VLIM_W-1:0]          step_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			axis_s1        <= axis_select;
			bal_s1         <= balance_velocity;
			rot_s1         <= rotation_velocity;
			corr_s1        <= side_correction;
			term_s1        <= err_prod_sh[TERM_W-1:0];
			smooth_s1      <= smoothed_velocity;
			manual_s1      <= manual_velocity;
			run_s1         <= run_in;
			index_drive_s1 <= index_drive_in;
			landing_s1     <= landing_active;
			step_s1        <= step_prod[STEP_P_W-1:DT_W];
		end
	end

	// ------------------------------------------------------------------------
	// per-axis state
	// ------------------------------------------------------------------------
	logic signed [VEL_W-1:0] prev_vel_q [NUM_AXES];
	logic                    run_flag_q [NUM_AXES];
	logic [CUR_W-1:0]        last_lim_q [NUM_AXES];

	logic [SLOT_W-1:0] slot;

	// with a single slot both axes share it
	always_comb begin
		if (int'(axis_s1) < NUM_AXES)
			slot = SLOT_W'(axis_s1);
		else
			slot = SLOT_W'(NUM_AXES - 1);
	end

	// ------------------------------------------------------------------------
	// second stage: state, velocity source, slew, clamp
	// ------------------------------------------------------------------------
	logic signed [VEL_W-1:0]  prev;
	logic                     run_flag;
	logic [CUR_W-1:0]         wanted_lim;
	logic                     lim_write;
	state_req_t               request;
	logic signed [SUM_W-1:0]  bal_sum;
	logic signed [SUM_W-1:0]  target;
	logic signed [DIFF_W-1:0] diff;
	logic signed [FAR_W-1:0]  far_diff;
	logic signed [FAR_W-1:0]  far_abs;
	logic                     applied;
	logic signed [DIFF_W-1:0] step_s;
	logic signed [DIFF_W-1:0] diff_cl;
	logic signed [DIFF_W-1:0] pre_clamp;
	logic signed [DIFF_W-1:0] vlim;
	logic signed [DIFF_W-1:0] vel_final;

	assign prev     = prev_vel_q[slot];
	assign run_flag = run_flag_q[slot];

	// current limit selection, write flagged on change
	assign wanted_lim = landing_s1 ? current_limit_landing_q : current_limit_normal_q;
	assign lim_write  = wanted_lim != last_lim_q[slot];

	// run transitions
	always_comb begin
		if (run_s1 && !run_flag)
			request = REQ_CLOSED_LOOP;
		else if (!run_s1 && run_flag)
			request = REQ_IDLE;
		else
			request = REQ_NONE;
	end

	// balance terms: left axis b - r + c - g, right axis -(b + r + c + g)
	always_comb begin
		if (axis_s1)
			bal_sum = -(SUM_W'(bal_s1) + SUM_W'(rot_s1) + SUM_W'(corr_s1)
				+ SUM_W'(term_s1));
		else
			bal_sum = SUM_W'(bal_s1) - SUM_W'(rot_s1) + SUM_W'(corr_s1)
				- SUM_W'(term_s1);
	end

	// velocity source: zero when not running, else priority index search > balance > manual
	always_comb begin
		if (!run_s1)
			target = '0;
		else if (index_drive_s1)
			target = axis_s1 ? INDEX_SPEED : -INDEX_SPEED;
		else if (balance_enable_q)
			target = bal_sum;
		else
			target = SUM_W'(manual_s1);
	end

	assign diff = DIFF_W'(target) - DIFF_W'(prev);

	// slip distance: left prev - smooth, right -prev - smooth
	always_comb begin
		if (axis_s1)
			far_diff = -FAR_W'(prev) - FAR_W'(smooth_s1);
		else
			far_diff = FAR_W'(prev) - FAR_W'(smooth_s1);
		far_abs = far_diff[FAR_W-1] ? -far_diff : far_diff;
	end

	// braking far from the smoothed speed skips the slew limit
	assign applied = !((far_abs > FAR_LIMIT) && ((diff < 0) != (prev < 0)));

	assign step_s = DIFF_W'($signed({1'b0, step_s1}));
	assign vlim   = DIFF_W'($signed({1'b0, velocity_limit_q}));

	always_comb begin
		if (diff > step_s)
			diff_cl = step_s;
		else if (diff < -step_s)
			diff_cl = -step_s;
		else
			diff_cl = diff;

		pre_clamp = applied ? (DIFF_W'(prev) + diff_cl) : DIFF_W'(target);

		if (pre_clamp < -vlim)
			vel_final = -vlim;
		else if (pre_clamp > vlim)
			vel_final = vlim;
		else
			vel_final = pre_clamp;
	end

	// state update as the request leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				prev_vel_q[i] <= '0;
				run_flag_q[i] <= 1'b0;
				last_lim_q[i] <= '0;
			end
		end else if (s1_fire) begin
			prev_vel_q[slot] <= vel_final[VEL_W-1:0];
			run_flag_q[slot] <= run_s1;
			last_lim_q[slot] <= wanted_lim;
		end
	end

	// ------------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------------
	logic                    axis_out_q;
	logic signed [VEL_W-1:0] velocity_command_q;
	logic                    running_q;
	state_req_t              state_request_q;
	logic                    current_limit_write_q;
	logic [CUR_W-1:0]        current_limit_value_q;
	logic                    accel_limit_applied_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			axis_out_q            <= axis_s1;
			velocity_command_q    <= vel_final[VEL_W-1:0];
			running_q             <= run_s1;
			state_request_q       <= request;
			current_limit_write_q <= lim_write;
			current_limit_value_q <= wanted_lim;
			accel_limit_applied_q <= applied;
		end
	end

	assign out_valid           = out_valid_q;
	assign axis_out            = axis_out_q;
	assign velocity_command    = velocity_command_q;
	assign running             = running_q;
	assign state_request       = state_request_q;
	assign current_limit_write = current_limit_write_q;
	assign current_limit_value = current_limit_value_q;
	assign accel_limit_applied = accel_limit_applied_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while a stage is free");

	a_closed_loop_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && state_request == REQ_CLOSED_LOOP) |-> running)
		else $error("closed loop request without running motor");

	a_idle_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && state_request == REQ_IDLE) |-> !running)
		else $error("idle request with running motor");

	a_velocity_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((FAR_W'(velocity_command) <= FAR_W'($signed({1'b0, velocity_limit_q})))
			&& (FAR_W'(velocity_command) >= -FAR_W'($signed({1'b0, velocity_limit_q})))))
		else $error("velocity command outside the velocity limit");

	a_stopped_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !running && !accel_limit_applied) |-> (velocity_command == '0))
		else $error("stopped motor with bypassed slew but nonzero command");

endmodule
